// ===== hdl/stpc_pkg.sv =====
// ----------------------------------------------------------------------------
// stpc_pkg
// Shared types and constants of the target bus phase controller.
// ----------------------------------------------------------------------------
package stpc_pkg;

   localparam int QUEUE_DEPTH   = 4096;
   localparam int QADDR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QFILL_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int CMD_MAX_BYTES = 10;
   localparam int CADDR_BITS    = $clog2(CMD_MAX_BYTES);
   localparam int CCNT_BITS     = $clog2(CMD_MAX_BYTES + 1);

   localparam logic [1:0] OP_LINES = 2'd0;
   localparam logic [1:0] OP_PORT  = 2'd1;
   localparam logic [1:0] OP_QUEUE = 2'd2;
   localparam logic [1:0] OP_BEGIN = 2'd3;

   localparam logic [2:0] PH_FREE = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_DIN  = 3'd2;
   localparam logic [2:0] PH_DOUT = 3'd3;
   localparam logic [2:0] PH_MIN  = 3'd4;
   localparam logic [2:0] PH_MOUT = 3'd5;
   localparam logic [2:0] PH_STAT = 3'd6;

   typedef struct packed {
      logic       bsy;
      logic       req;
      logic       cd;
      logic       io;
      logic       msg;
   } tgt_lines_type;

   typedef struct packed {
      logic       sel;
      logic       atn;
      logic       ack;
      logic       rst;
   } ini_lines_type;

   typedef struct packed {
      logic [2:0]    phase;
      tgt_lines_type tgt;
      ini_lines_type ini;
      logic [7:0]    port;
      logic          status_sent;
      logic          message_sent;
      logic          done_pending;
      logic [CCNT_BITS-1:0] ccount;
   } ctl_state_type;

   typedef struct packed {
      logic        cmd_valid;
      logic        done_set;
      logic        done_clr;
      logic        ready_clr;
   } pulse_type;

   function automatic logic [3:0] cmd_size(input logic [7:0] opc);
      case (opc)
         8'h00, 8'h08: cmd_size = 4'd6;
         8'hD8, 8'hD9, 8'hDA, 8'hDD, 8'hDE: cmd_size = 4'd10;
         default: cmd_size = 4'd0;
      endcase
   endfunction

   function automatic tgt_lines_type phase_lines(input logic [2:0] ph);
      tgt_lines_type t;
      t = '0;
      case (ph)
         PH_FREE: t = '0;
         PH_CMD:  begin t.bsy = 1'b1; t.cd = 1'b1; t.req = 1'b1; end
         PH_DIN:  begin t.bsy = 1'b1; t.io = 1'b1; end
         PH_DOUT: begin t.bsy = 1'b1; t.req = 1'b1; end
         PH_MIN:  begin t = '1; end
         PH_MOUT: begin t.bsy = 1'b1; t.cd = 1'b1; t.msg = 1'b1; t.req = 1'b1; end
         default: begin t.bsy = 1'b1; t.cd = 1'b1; t.io = 1'b1; t.req = 1'b1; end
      endcase
      return t;
   endfunction

endpackage

// ===== hdl/stpc_ram.sv =====
// ----------------------------------------------------------------------------
// stpc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module stpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/stpc_engine.sv =====
// ----------------------------------------------------------------------------
// stpc_engine
// Settle logic: runs the phase rules to a fixed point combinationally, using
// the head byte of the data-in queue that has been prefetched.
// ----------------------------------------------------------------------------
module stpc_engine
   import stpc_pkg::*;
(
   input  ctl_state_type        st_in,
   input  logic [7:0]           head_byte,
   input  logic [QFILL_BITS-1:0] fill_in,
   input  logic [7:0]           cbyte [CMD_MAX_BYTES],
   output ctl_state_type        st_out,
   output logic [QFILL_BITS-1:0] fill_out,
   output logic                 pop,
   output logic                 cwr_en,
   output logic [CADDR_BITS-1:0] cwr_addr,
   output logic [7:0]           cwr_data,
   output pulse_type            pulses
);
   // A settle can pop the queue at most once: after a pop REQ is high and
   // the pass stops until the next ACK. Every other chain is a handful of
   // steps, so eight unrolled passes reach the fixed point.
   localparam int PASSES = 8;

   always_comb begin
      ctl_state_type s;
      logic moved;
      logic [3:0] sz;
      logic [2:0] tgt_ph;
      logic go;
      s        = st_in;
      fill_out = fill_in;
      pop      = 1'b0;
      cwr_en   = 1'b0;
      cwr_addr = '0;
      cwr_data = s.port;
      pulses   = '0;
      moved    = 1'b1;
      sz       = '0;
      tgt_ph   = PH_FREE;
      go       = 1'b0;
      for (int i = 0; i < PASSES; i++) begin
         if (moved) begin
            moved = 1'b0;
            go    = 1'b0;
            if (!s.tgt.bsy && s.ini.sel) begin
               go = 1'b1; tgt_ph = PH_CMD;
            end else if (!s.ini.ack && s.ini.atn && !s.tgt.req) begin
               go = 1'b1; tgt_ph = PH_MOUT;
            end else begin
               case (s.phase)
                  PH_CMD: begin
                     if (s.tgt.req && s.ini.ack) begin
                        s.tgt.req = 1'b0; moved = 1'b1;
                        if (s.ccount < CCNT_BITS'(CMD_MAX_BYTES)) begin
                           cwr_en   = 1'b1;
                           cwr_addr = s.ccount[CADDR_BITS-1:0];
                           cwr_data = s.port;
                           s.ccount = s.ccount + 1'b1;
                        end
                     end else if (!s.tgt.req && !s.ini.ack && s.ccount != 0) begin
                        sz = cmd_size(cbyte[0]);
                        if (sz == 0) begin
                           s.ccount = '0;
                           s.status_sent = 1'b0; s.message_sent = 1'b0;
                           s.port = '0; go = 1'b1; tgt_ph = PH_STAT;
                        end else if (CCNT_BITS'(sz) <= s.ccount) begin
                           pulses.cmd_valid = 1'b1;
                           s.ccount = '0;
                        end else begin
                           s.tgt.req = 1'b1; moved = 1'b1;
                        end
                     end
                  end
                  PH_DIN: begin
                     if (s.tgt.req && s.ini.ack) begin
                        s.tgt.req = 1'b0; moved = 1'b1;
                     end else if (!s.tgt.req && !s.ini.ack) begin
                        if (fill_out != 0) begin
                           s.port = head_byte; pop = 1'b1;
                           fill_out = fill_out - 1'b1;
                           s.tgt.req = 1'b1; moved = 1'b1;
                        end else begin
                           pulses.ready_clr = 1'b1;
                           if (s.done_pending) begin
                              s.done_pending = 1'b0; pulses.done_set = 1'b1;
                           end
                           s.status_sent = 1'b0; s.message_sent = 1'b0;
                           s.port = '0; go = 1'b1; tgt_ph = PH_STAT;
                        end
                     end
                  end
                  PH_MIN: begin
                     if (s.tgt.req && s.ini.ack) begin
                        s.tgt.req = 1'b0; moved = 1'b1; s.message_sent = 1'b1;
                     end else if (!s.tgt.req && !s.ini.ack && s.message_sent) begin
                        s.message_sent = 1'b0; go = 1'b1; tgt_ph = PH_FREE;
                     end
                  end
                  PH_STAT: begin
                     if (s.tgt.req && s.ini.ack) begin
                        s.tgt.req = 1'b0; moved = 1'b1; s.status_sent = 1'b1;
                     end else if (!s.tgt.req && !s.ini.ack && s.status_sent) begin
                        s.status_sent = 1'b0; s.port = '0;
                        go = 1'b1; tgt_ph = PH_MIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (go && s.phase != tgt_ph) begin
               moved   = 1'b1;
               s.phase = tgt_ph;
               s.tgt   = phase_lines(tgt_ph);
               if (tgt_ph == PH_FREE) begin
                  pulses.done_clr = 1'b1;
               end
            end
         end
      end
      st_out = s;
   end
endmodule

// ===== hdl/scsi_target_phase_controller_unit.sv =====
// Timing: a result item is registered in the cycle after its input item is accepted;
// no new item is taken until then. The head byte of the data-in queue is read
// from memory at the accepting edge, and the following cycle runs the settle logic
// while the input is held off.
// Reset: synchronous, active high; bus free, all lines low, queue and command
// buffer empty. The queue and command memories are not cleared.
// ----------------------------------------------------------------------------
// scsi_target_phase_controller_unit
// Target side of a SCSI-like bus: phase engine, command collection and data-in
// queue. One result item is produced for every input item.
// ----------------------------------------------------------------------------
module scsi_target_phase_controller_unit
   import stpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: data_byte[7:0], final_block[8], zero pad [15:9]
   input  logic [15:0] req_tdata,
   // tuser: op[1:0], sel_line[2], atn_line[3], ack_line[4], rst_line[5]
   input  logic [5:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: bus_phase[2:0], status_byte[10:3], data_port[18:11],
   // cmd_valid[19], cmd_opcode[27:20], cmd_args[91:28], cmd_last_arg[99:92],
   // irq_done_set[100], irq_done_clear[101], irq_ready_clear[102], pad to 104
   output logic [103:0] rsp_tdata
);
   // The item is captured while the queue head is read from the memory; next the
   // settle logic runs and the result is registered.
   logic        busy_ff, busy_in;
   logic [1:0]  op_ff;
   logic        sel_ff, atn_ff, ack_ff, rst_ff, fin_ff;
   logic [7:0]  byte_ff;
   ctl_state_type st_ff, st_in;
   logic [QADDR_BITS-1:0] head_ff, head_in;
   logic [QFILL_BITS-1:0] fill_ff, fill_in;
   logic [7:0]  cbuf_ff [CMD_MAX_BYTES];
   logic        out_v_ff;
   logic [103:0] out_d_ff;
   logic [103:0] out_d_in;

   logic [7:0]  head_byte;
   logic        q_wr;
   logic [QADDR_BITS-1:0] q_waddr;
   ctl_state_type eng_in, eng_out;
   logic [QFILL_BITS-1:0] eng_fill;
   logic        eng_pop, cwr_en;
   logic [CADDR_BITS-1:0] cwr_addr;
   logic [7:0]  cwr_data;
   pulse_type   pulses;
   logic        run;
   logic [QFILL_BITS:0] tail_sum;

   assign req_tready = !busy_ff && (!out_v_ff || rsp_tready);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   stpc_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .wr_en(q_wr), .wr_addr(q_waddr), .wr_data(byte_ff),
      .rd_addr(head_ff), .rd_data(head_byte));

   stpc_engine u_engine (
      .st_in(eng_in), .head_byte(head_byte), .fill_in(fill_ff),
      .cbyte(cbuf_ff), .st_out(eng_out), .fill_out(eng_fill), .pop(eng_pop),
      .cwr_en(cwr_en), .cwr_addr(cwr_addr), .cwr_data(cwr_data),
      .pulses(pulses));

   always_comb begin
      tail_sum = {1'b0, QFILL_BITS'(head_ff)} + {1'b0, fill_ff};
      if (tail_sum >= (QFILL_BITS+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (QFILL_BITS+1)'(QUEUE_DEPTH);
      end
      q_waddr = tail_sum[QADDR_BITS-1:0];
      q_wr    = busy_ff && op_ff == OP_QUEUE && fill_ff < QFILL_BITS'(QUEUE_DEPTH);
   end

   always_comb begin
      ctl_state_type s;
      s   = st_ff;
      run = 1'b0;
      case (op_ff)
         OP_LINES: begin
            s.ini = '{sel: sel_ff, atn: atn_ff, ack: ack_ff, rst: rst_ff};
            run   = s.ini != st_ff.ini;
         end
         OP_BEGIN: begin
            if (fin_ff) s.done_pending = 1'b1;
            if (s.phase != PH_DIN) begin
               s.phase = PH_DIN;
               s.tgt   = phase_lines(PH_DIN);
               run     = 1'b1;
            end
         end
         default: begin
         end
      endcase
      eng_in = s;
   end

   always_comb begin
      ctl_state_type s;
      pulse_type p;
      logic [63:0] args;
      logic [7:0]  last;
      logic        bus_rst;
      s       = eng_in;
      p       = '0;
      head_in = head_ff;
      fill_in = fill_ff;
      bus_rst = 1'b0;
      args    = '0;
      last    = '0;
      case (op_ff)
         OP_PORT:  s.port = byte_ff;
         OP_QUEUE: if (q_wr) fill_in = fill_ff + 1'b1;
         default: begin
         end
      endcase
      if (run) begin
         if (eng_in.ini.rst) begin
            bus_rst        = 1'b1;
            s.tgt          = '0;
            s.ini.atn      = 1'b0;
            s.ini.ack      = 1'b0;
            s.phase        = PH_FREE;
            s.port         = '0;
            s.done_pending = 1'b0;
            s.status_sent  = 1'b0;
            s.message_sent = 1'b0;
            s.ccount       = '0;
            head_in        = '0;
            fill_in        = '0;
         end else begin
            s       = eng_out;
            p       = pulses;
            fill_in = eng_fill;
            if (eng_pop) begin
               head_in = (32'(head_ff) + 1 >= QUEUE_DEPTH) ? '0 : head_ff + 1'b1;
            end
         end
      end
      if (p.cmd_valid) begin
         // Bytes beyond the collected count read as zero.
         for (int i = 1; i < 9; i++) begin
            if (i < 32'(eng_in.ccount) + (cwr_en ? 1 : 0)) begin
               args[8*(i-1) +: 8] = (cwr_en && cwr_addr == CADDR_BITS'(i)) ?
                                    cwr_data : cbuf_ff[i];
            end
         end
         if (eng_in.ccount + (cwr_en ? 1 : 0) > 9) begin
            last = (cwr_en && cwr_addr == CADDR_BITS'(9)) ? cwr_data : cbuf_ff[9];
         end
      end
      st_in   = s;
      busy_in = 1'b0;
      out_d_in = {1'b0, p.ready_clr, p.done_clr, p.done_set, last, args,
                  p.cmd_valid ? cbuf_ff[0] : 8'h00, p.cmd_valid,
                  s.port,
                  s.tgt.bsy, s.tgt.req, s.tgt.msg, s.tgt.cd, s.tgt.io, 3'b000,
                  s.phase};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         st_ff    <= '0;
         head_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            busy_ff <= busy_in;
         end
         if (busy_ff) begin
            out_v_ff <= 1'b1;
            st_ff    <= st_in;
            head_ff  <= head_in;
            fill_ff  <= fill_in;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tuser[1:0];
         sel_ff  <= req_tuser[2];
         atn_ff  <= req_tuser[3];
         ack_ff  <= req_tuser[4];
         rst_ff  <= req_tuser[5];
         byte_ff <= req_tdata[7:0];
         fin_ff  <= req_tdata[8];
      end
      if (busy_ff) begin
         out_d_ff <= out_d_in;
         if (run && !eng_in.ini.rst && cwr_en) begin
            cbuf_ff[cwr_addr] <= cwr_data;
         end
      end
   end
endmodule

// ===== hdl/stpc_checker.sv =====
// ----------------------------------------------------------------------------
// stpc_props
// Port-level checks of the phase controller's input handshake and result stream.
// ----------------------------------------------------------------------------
module stpc_props
   import stpc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 rsp_tvalid)
      else $error("result missing after item");
   a_free_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == PH_FREE |-> rsp_tdata[10] == 1'b0)
      else $error("busy in bus free");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd7)
      else $error("bad phase");
endmodule

bind scsi_target_phase_controller_unit stpc_props u_stpc_props (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

// ===== verif/stpc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stpc_checker
// Watches both channels of the target phase controller, predicts each result
// item from the accepted input items and compares it field by field.
// ----------------------------------------------------------------------------
module stpc_checker
   import stpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [15:0]  req_tdata,
   input  logic [5:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   output int           mismatch_count,
   output int           pending_count,
   output int           command_count_seen
);

   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  status;
      logic [7:0]  port;
      logic        cmd_valid;
      logic [7:0]  opcode;
      logic [63:0] args;
      logic [7:0]  last_arg;
      logic        done_set;
      logic        done_clr;
      logic        ready_clr;
   } bus_result_type;

   // Ring of predicted result items; only a couple are ever outstanding.
   localparam int EXP_DEPTH = 16;
   bus_result_type expected_results [EXP_DEPTH];
   int          exp_wr, exp_rd;

   // Shadow copy of the controller state.
   logic [2:0]  phase;
   logic        sel, atn, ack, rst, bsy, req, cd, io, msg;
   logic [7:0]  port;
   logic [7:0]  cmd_buf [CMD_MAX_BYTES];
   int          cmd_cnt;
   logic [7:0]  resp_queue [QUEUE_DEPTH];
   int          q_head, q_fill;
   logic        status_done, message_done, done_pending;
   logic        moved;
   bus_result_type r;

   function automatic int opcode_length(input logic [7:0] opc);
      case (opc)
         8'h00, 8'h08: return 6;
         8'hD8, 8'hD9, 8'hDA, 8'hDD, 8'hDE: return 10;
         default: return 0;
      endcase
   endfunction

   task automatic set_req(input logic v);
      if (req != v) begin
         req = v;
         moved = 1'b1;
      end
   endtask

   task automatic enter_phase(input logic [2:0] ph);
      if (phase == ph) return;
      moved = 1'b1;
      phase = ph;
      {bsy, cd, io, msg, req} = '0;
      case (ph)
         PH_FREE: r.done_clr = 1'b1;
         PH_CMD:  {bsy, cd, req} = 3'b111;
         PH_DIN:  {bsy, io} = 2'b11;
         PH_DOUT: {bsy, req} = 2'b11;
         PH_MIN:  {bsy, cd, io, msg, req} = 5'b11111;
         PH_MOUT: {bsy, cd, msg, req} = 4'b1111;
         default: {bsy, cd, io, req} = 4'b1111;
      endcase
   endtask

   task automatic go_status();
      status_done = 1'b0;
      message_done = 1'b0;
      port = '0;
      enter_phase(PH_STAT);
   endtask

   task automatic step_command();
      int len;
      if (req && ack) begin
         set_req(1'b0);
         if (cmd_cnt < CMD_MAX_BYTES) begin
            cmd_buf[cmd_cnt] = port;
            cmd_cnt++;
         end
      end else if (!req && !ack && cmd_cnt > 0) begin
         len = opcode_length(cmd_buf[0]);
         if (len == 0) begin
            cmd_cnt = 0;
            go_status();
         end else if (len <= cmd_cnt) begin
            r.cmd_valid = 1'b1;
            r.opcode = cmd_buf[0];
            r.args = '0;
            for (int i = 1; i < 9 && i < cmd_cnt; i++)
               r.args[8*(i-1) +: 8] = cmd_buf[i];
            r.last_arg = (cmd_cnt > 9) ? cmd_buf[9] : 8'h00;
            cmd_cnt = 0;
         end else begin
            set_req(1'b1);
         end
      end
   endtask

   task automatic step_data_in();
      if (req && ack) begin
         set_req(1'b0);
      end else if (!req && !ack) begin
         if (q_fill > 0) begin
            port = resp_queue[q_head];
            q_head = (q_head + 1 >= QUEUE_DEPTH) ? 0 : q_head + 1;
            q_fill--;
            set_req(1'b1);
         end else begin
            r.ready_clr = 1'b1;
            if (done_pending) begin
               done_pending = 1'b0;
               r.done_set = 1'b1;
            end
            go_status();
         end
      end
   endtask

   task automatic step_status();
      if (req && ack) begin
         set_req(1'b0);
         status_done = 1'b1;
      end else if (!req && !ack && status_done) begin
         status_done = 1'b0;
         port = '0;
         enter_phase(PH_MIN);
      end
   endtask

   task automatic step_message();
      if (req && ack) begin
         set_req(1'b0);
         message_done = 1'b1;
      end else if (!req && !ack && message_done) begin
         message_done = 1'b0;
         enter_phase(PH_FREE);
      end
   endtask

   // Runs the phase rules until nothing moves; a held bus reset wins outright.
   task automatic run_phase_rules();
      int n;
      n = 0;
      if (rst) begin
         {ack, atn, bsy, cd, io, msg, req} = '0;
         phase = PH_FREE;
         port = '0;
         done_pending = 1'b0;
         status_done = 1'b0;
         message_done = 1'b0;
         cmd_cnt = 0;
         q_head = 0;
         q_fill = 0;
         return;
      end
      do begin
         moved = 1'b0;
         if (!bsy && sel) enter_phase(PH_CMD);
         else if (!ack && atn && !req) enter_phase(PH_MOUT);
         else begin
            case (phase)
               PH_CMD:  step_command();
               PH_DIN:  step_data_in();
               PH_MIN:  step_message();
               PH_STAT: step_status();
               default: ;
            endcase
         end
         n++;
      end while (moved && n < 64);
   endtask

   task automatic predict_bus_result(input logic [15:0] d, input logic [5:0] u);
      logic [1:0] op;
      int t;
      op = u[1:0];
      r = '0;
      if (op == OP_LINES) begin
         if ({rst, ack, atn, sel} != u[5:2]) begin
            {rst, ack, atn, sel} = {u[5], u[4], u[3], u[2]};
            run_phase_rules();
         end
      end else if (op == OP_PORT) begin
         port = d[7:0];
      end else if (op == OP_QUEUE) begin
         if (q_fill < QUEUE_DEPTH) begin
            t = q_head + q_fill;
            if (t >= QUEUE_DEPTH) t -= QUEUE_DEPTH;
            resp_queue[t] = d[7:0];
            q_fill++;
         end
      end else begin
         if (d[8]) done_pending = 1'b1;
         moved = 1'b0;
         enter_phase(PH_DIN);
         if (moved) run_phase_rules();
      end
      r.phase = phase;
      r.status = {bsy, req, msg, cd, io, 3'b000};
      r.port = port;
      expected_results[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
      if (r.cmd_valid) command_count_seen++;
   endtask

   task automatic report(input string name, input logic [63:0] e, input logic [63:0] a);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, name, e, a);
   endtask

   always @(posedge clock) begin
      bus_result_type e, a;
      if (reset) begin
         {sel, atn, ack, rst, bsy, req, cd, io, msg} = '0;
         port = '0;
         cmd_cnt = 0;
         q_head = 0;
         q_fill = 0;
         {status_done, message_done, done_pending} = '0;
         phase = PH_FREE;
      end else begin
         if (req_tvalid && req_tready) predict_bus_result(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            a = {rsp_tdata[2:0], rsp_tdata[10:3], rsp_tdata[18:11], rsp_tdata[19],
                 rsp_tdata[27:20], rsp_tdata[91:28], rsp_tdata[99:92], rsp_tdata[100],
                 rsp_tdata[101], rsp_tdata[102]};
            if (exp_wr == exp_rd) begin
               report("unexpected result item", 0, 1);
            end else begin
               e = expected_results[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (e.phase != a.phase) report("bus_phase", e.phase, a.phase);
               if (e.status != a.status) report("status_byte", e.status, a.status);
               if (e.port != a.port) report("data_port", e.port, a.port);
               if (e.cmd_valid != a.cmd_valid) report("cmd_valid", e.cmd_valid, a.cmd_valid);
               if (e.opcode != a.opcode) report("cmd_opcode", e.opcode, a.opcode);
               if (e.args != a.args) report("cmd_args", e.args, a.args);
               if (e.last_arg != a.last_arg) report("cmd_last_arg", e.last_arg, a.last_arg);
               if (e.done_set != a.done_set) report("irq_done_set", e.done_set, a.done_set);
               if (e.done_clr != a.done_clr) report("irq_done_clear", e.done_clr, a.done_clr);
               if (e.ready_clr != a.ready_clr)
                  report("irq_ready_clear", e.ready_clr, a.ready_clr);
            end
         end
      end
      pending_count <= exp_wr - exp_rd;
   end

   initial begin
      mismatch_count = 0;
      pending_count = 0;
      command_count_seen = 0;
      exp_wr = 0;
      exp_rd = 0;
   end

endmodule

// ===== verif/tb_scsi_target_phase_controller_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scsi_target_phase_controller_unit
// Drives initiator line updates, port writes and response bytes into the
// target phase controller, mostly as complete bus transactions with random
// content, and lets the checker compare every result item.
// ----------------------------------------------------------------------------
module tb_scsi_target_phase_controller_unit;
   import stpc_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int ITEM_TARGET = 600;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;
   logic [5:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;

   int mismatch_count, pending_count, command_count_seen;
   int items_sent;
   int burst_left;
   int idle_cycles;
   int stall_mode;
   int stall_timer;
   logic [7:0] known_opcodes [7] = '{8'h00, 8'h08, 8'hD8, 8'hD9, 8'hDA, 8'hDD, 8'hDE};

   scsi_target_phase_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   stpc_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .command_count_seen (command_count_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver alternates between stretches of full readiness and stretches
   // of random stalls, so back pressure lands on every phase of the work.
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_timer <= $urandom_range(20, 200);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      if (stall_mode == 0) rsp_tready <= 1'b1;
      else if (stall_mode == 1) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= ($urandom_range(0, 1) != 0);
   end

   // Watchdog: a stretch as long as IDLE_LIMIT with no item moving on either side is a hang.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d result items outstanding", pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Sends one item. The sender works in bursts; between bursts tvalid is often
   // dropped for a random gap, and every burst holds at least one item.
   task automatic send_item(input logic [1:0] op, input logic [3:0] lines,
                            input logic [7:0] data, input logic fin);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      // lines holds {rst, ack, atn, sel}
      req_tuser  <= {lines, op};
      req_tdata  <= {7'b0, fin, data};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic set_lines(input logic sel, input logic atn, input logic ack,
                            input logic rst);
      send_item(OP_LINES, {rst, ack, atn, sel}, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
   endtask

   // Bus reset pulse brings the target back to bus free from any state.
   task automatic bus_reset();
      set_lines(1'b0, 1'b0, 1'b0, 1'b1);
      set_lines(1'b0, 1'b0, 1'b0, 1'b0);
   endtask

   // One REQ/ACK exchange with the target.
   task automatic ack_cycle(input logic sel);
      set_lines(sel, 1'b0, 1'b1, 1'b0);
      set_lines(sel, 1'b0, 1'b0, 1'b0);
   endtask

   // A complete transaction: selection, command bytes, response bytes, the data-in
   // transfer, status, message-in and bus free (unknown opcode: no data-in part).
   task automatic transaction(input logic [7:0] opcode, input int arg_fill,
                              input int resp_bytes, input logic fin);
      int len;
      logic sel;
      len = (opcode == 8'h00 || opcode == 8'h08) ? 6 :
            (opcode inside {8'hD8, 8'hD9, 8'hDA, 8'hDD, 8'hDE}) ? 10 : 1;
      sel = 1'($urandom_range(0, 1));
      set_lines(1'b1, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < len; i++) begin
         send_item(OP_PORT, 4'($urandom), (i == 0) ? opcode :
                   (arg_fill >= 0) ? arg_fill[7:0] : 8'($urandom_range(0, 255)),
                   1'($urandom));
         ack_cycle(sel);
      end
      if (len > 1) begin
         for (int i = 0; i < resp_bytes; i++)
            send_item(OP_QUEUE, 4'($urandom), 8'($urandom_range(0, 255)), 1'($urandom));
         send_item(OP_BEGIN, 4'($urandom), 8'($urandom), fin);
         for (int i = 0; i < resp_bytes; i++) ack_cycle(1'b0);
      end
      // Status byte and message byte.
      ack_cycle(1'b0);
      ack_cycle(1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      items_sent = 0;
      burst_left = 0;
      idle_cycles = 0;
      stall_mode = 0;
      stall_timer = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: a six-byte and a ten-byte command with extreme argument
      // values, an unknown opcode, an empty response, attention, and a begin
      // response issued while data-in is already active.
      transaction(8'h00, 8'hFF, 1, 1'b1);
      transaction(8'hDE, 8'h00, 0, 1'b0);
      transaction(8'hFF, -1, 0, 1'b0);
      set_lines(1'b0, 1'b1, 1'b0, 1'b0);
      bus_reset();
      send_item(OP_QUEUE, 4'h0, 8'hFF, 1'b0);
      send_item(OP_QUEUE, 4'h0, 8'h00, 1'b0);
      send_item(OP_BEGIN, 4'hF, 8'h00, 1'b1);
      send_item(OP_BEGIN, 4'h0, 8'hFF, 1'b0);
      bus_reset();

      // Random part: mostly whole transactions with random content, the rest
      // noise items and broken-off sequences that a bus reset then recovers.
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 8))
                  send_item(2'($urandom_range(0, 3)),
                            {($urandom_range(0, 7) == 0), 3'($urandom_range(0, 7))},
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               bus_reset();
            end
            2:
               transaction(8'($urandom_range(0, 255)), -1, $urandom_range(0, 3),
                           1'($urandom_range(0, 1)));
            default:
               transaction(known_opcodes[$urandom_range(0, 6)],
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : -1,
                           $urandom_range(0, 4), 1'($urandom_range(0, 1)));
         endcase
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d items; %0d commands completed across full transactions,",
               items_sent, command_count_seen);
      $display("bus resets, attention, unknown opcodes and random line noise.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== scsi_target_phase_controller_unit.f =====
hdl/stpc_pkg.sv
hdl/stpc_ram.sv
hdl/stpc_engine.sv
hdl/scsi_target_phase_controller_unit.sv
hdl/stpc_checker.sv
verif/stpc_checker.sv
verif/tb_scsi_target_phase_controller_unit.sv
